// ===== rtl/svbb_pkg.sv =====
// ----------------------------------------------------------------------------
// svbb_pkg: shared types and helpers of the skinned vertex bounding box
// Holds the queue word format, the operation codes and the saturation helper.
// ----------------------------------------------------------------------------
package svbb_pkg;

  localparam int unsigned MaxBonesDef = 64;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_VERTEX = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [5:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        indices;
    logic [63:0]        weights;
  } cmd_t;

  localparam logic signed [65:0] S32Max = 66'sd2147483647;
  localparam logic signed [65:0] S32Min = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7fffffff;
    end else if (v < S32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/skinned_vertex_bounding_box.sv =====
// ----------------------------------------------------------------------------
// skinned_vertex_bounding_box: skinned vertex bounds over a bone matrix store
// Takes matrix writes, vertices and report requests, and returns the box.
// ----------------------------------------------------------------------------
// The input channel takes one word per cycle while in_stall_o is low. A type 0
// word writes one matrix element, a type 1 word skins one vertex into the box,
// a type 2 word returns the box on the output channel and clears it. Type 3
// words and writes to bones at or beyond MAX_BONES are dropped at intake.
// A two-word queue sits between intake and the engine, so words are taken
// while the engine is busy until the queue fills.
// A vertex runs as a sequence of steps: one multiply-accumulate unit forms
// 48 blend products, one matrix read each, then 12 transform products,
// followed by pipeline drain and the box update. A report loads the output
// register and appears on the output in the next cycle.
// The result stays in an output register while out_stall_i is high; a further
// report waits in the queue until that register is free.
// Reset empties the queue and clears the box; the matrix store holds no reset
// value and must be written before use.
// ----------------------------------------------------------------------------
module skinned_vertex_bounding_box #(
  parameter int unsigned MAX_BONES = svbb_pkg::MaxBonesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         target_bone_i,
  input  logic [3:0]         target_elem_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        bone_indices_i,
  input  logic [63:0]        bone_weights_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               box_valid_o,
  output logic signed [31:0] min_x_o,
  output logic signed [31:0] min_y_o,
  output logic signed [31:0] min_z_o,
  output logic signed [31:0] max_x_o,
  output logic signed [31:0] max_y_o,
  output logic signed [31:0] max_z_o
);
  import svbb_pkg::*;

  cmd_t in_cmd;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  always_comb begin
    in_cmd         = '0;
    in_cmd.op      = op_e'(req_type_i);
    in_cmd.bone    = target_bone_i;
    in_cmd.elem    = target_elem_i;
    in_cmd.value   = elem_value_i;
    in_cmd.pos_x   = pos_x_i;
    in_cmd.pos_y   = pos_y_i;
    in_cmd.pos_z   = pos_z_i;
    in_cmd.indices = bone_indices_i;
    in_cmd.weights = bone_weights_i;
  end

  svbb_front #(.MAX_BONES(MAX_BONES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_cmd_i   (in_cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  svbb_back #(.MAX_BONES(MAX_BONES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .box_valid_o(box_valid_o),
    .min_x_o    (min_x_o),
    .min_y_o    (min_y_o),
    .min_z_o    (min_z_o),
    .max_x_o    (max_x_o),
    .max_y_o    (max_y_o),
    .max_z_o    (max_z_o)
  );

endmodule

// ===== rtl/svbb_front.sv =====
// ----------------------------------------------------------------------------
// svbb_front: request intake
// Accepts words, drops those that have no effect and queues the rest.
// ----------------------------------------------------------------------------
module svbb_front #(
  parameter int unsigned MAX_BONES = svbb_pkg::MaxBonesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svbb_pkg::cmd_t      in_cmd_i,
  output logic                cmd_valid_o,
  output svbb_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);
  import svbb_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  logic       push;
  logic       pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign keep        = (in_cmd_i.op == OP_VERTEX) || (in_cmd_i.op == OP_REPORT) ||
                       ((in_cmd_i.op == OP_WRITE) &&
                        ({3'b000, in_cmd_i.bone} < 9'(MAX_BONES)));
  assign push        = in_valid_i && !in_stall_o && keep;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// ===== rtl/svbb_back.sv =====
// ----------------------------------------------------------------------------
// svbb_back: matrix store, skinning engine and box
// Runs queued commands; one shared multiply-accumulate unit blends and
// transforms each vertex, and reports leave through an output register.
// ----------------------------------------------------------------------------
module svbb_back #(
  parameter int unsigned MAX_BONES = svbb_pkg::MaxBonesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  svbb_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               box_valid_o,
  output logic signed [31:0] min_x_o,
  output logic signed [31:0] min_y_o,
  output logic signed [31:0] min_z_o,
  output logic signed [31:0] max_x_o,
  output logic signed [31:0] max_y_o,
  output logic signed [31:0] max_z_o
);
  import svbb_pkg::*;

  localparam int unsigned BoneW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int unsigned AddrW = BoneW + 4;
  localparam int unsigned Depth = (1 << AddrW);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_UPD   = 4'b1000
  } state_e;

  typedef struct packed {
    logic       v;
    logic       xf;
    logic       first;
    logic       last;
    logic       zero;
    logic [1:0] a;
    logic [1:0] c;
  } tag_t;

  logic [31:0] mem [Depth];

  state_e             state_q, state_d;
  logic [5:0]         cnt_q;
  logic               xf_q;
  logic [1:0]         xa_q, xc_q;
  logic signed [31:0] pos_q [3];
  logic [31:0]        idx_q;
  logic [63:0]        wgt_q;
  logic signed [31:0] m_q [3][4];
  logic signed [31:0] p_q [3];
  logic signed [31:0] box_min_q [3];
  logic signed [31:0] box_max_q [3];
  logic               seen_q;

  logic [31:0]        rd_q;
  logic signed [32:0] xop_q, wb_q;
  tag_t               t1_q, t2_q, t1_d;
  logic signed [65:0] prod_q, acc_q, acc_d, base;
  logic signed [32:0] opa, opb;

  logic               out_valid_q;
  logic               ob_valid_q;
  logic signed [31:0] omin_q [3];
  logic signed [31:0] omax_q [3];

  logic [1:0]         bs;
  logic [7:0]         bidx;
  logic               binr;
  logic               issue_b, issue_x;
  logic               do_write, do_vertex, do_report;
  logic [7:0]         wbone;

  assign bs        = cnt_q[1:0];
  assign bidx      = idx_q[8*bs +: 8];
  assign binr      = ({1'b0, bidx} < 9'(MAX_BONES));
  assign issue_b   = (state_q == ST_RUN) && !xf_q;
  assign issue_x   = (state_q == ST_RUN) && xf_q;
  assign wbone     = {2'b00, cmd_i.bone};
  assign do_write  = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_WRITE);
  assign do_vertex = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_VERTEX);
  assign do_report = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_REPORT) &&
                     (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = do_write || do_vertex || do_report ||
                     ((state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_NONE));

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[{wbone[BoneW-1:0], cmd_i.elem}] <= cmd_i.value;
    end
    if (issue_b) begin
      rd_q <= mem[{bidx[BoneW-1:0], cnt_q[3:2], cnt_q[5:4]}];
    end
  end

  always_comb begin
    t1_d = '0;
    if (issue_b) begin
      t1_d.v     = 1'b1;
      t1_d.first = (bs == 2'd0);
      t1_d.last  = (bs == 2'd3);
      t1_d.zero  = !binr;
      t1_d.a     = cnt_q[5:4];
      t1_d.c     = cnt_q[3:2];
    end else if (issue_x) begin
      t1_d.v     = 1'b1;
      t1_d.xf    = 1'b1;
      t1_d.first = (xc_q == 2'd0);
      t1_d.last  = (xc_q == 2'd3);
      t1_d.a     = xa_q;
      t1_d.c     = xc_q;
    end
  end

  assign opa = t1_q.xf ? xop_q : (t1_q.zero ? 33'sd0 : {rd_q[31], rd_q});
  assign opb = t1_q.zero ? 33'sd0 : wb_q;

  always_comb begin
    if (!t2_q.first) begin
      base = acc_q;
    end else if (t2_q.xf) begin
      base = 66'sd32768;
    end else begin
      base = 66'sd16384;
    end
    acc_d = base + prod_q;
  end

  always_ff @(posedge clk_i) begin
    if (issue_b) begin
      wb_q <= {17'b0, wgt_q[16*bs +: 16]};
    end else if (issue_x) begin
      xop_q <= {m_q[xa_q][xc_q][31], m_q[xa_q][xc_q]};
      wb_q  <= (xc_q == 2'd3) ? 33'sd65536 : {pos_q[xc_q][31], pos_q[xc_q]};
    end
    prod_q <= opa * opb;
    if (t2_q.v) begin
      acc_q <= acc_d;
      if (t2_q.last) begin
        if (t2_q.xf) begin
          p_q[t2_q.a] <= sat32(acc_d >>> 16);
        end else begin
          m_q[t2_q.a][t2_q.c] <= sat32(acc_d >>> 15);
        end
      end
    end
    if (do_vertex) begin
      pos_q[0] <= cmd_i.pos_x;
      pos_q[1] <= cmd_i.pos_y;
      pos_q[2] <= cmd_i.pos_z;
      idx_q    <= cmd_i.indices;
      wgt_q    <= cmd_i.weights;
    end
    if (do_report) begin
      ob_valid_q <= seen_q;
      for (int i = 0; i < 3; i++) begin
        omin_q[i] <= box_min_q[i];
        omax_q[i] <= box_max_q[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_vertex) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (xf_q && (xa_q == 2'd2) && (xc_q == 2'd3)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!t1_q.v && !t2_q.v) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 6'd0;
      xf_q        <= 1'b0;
      xa_q        <= 2'd0;
      xc_q        <= 2'd0;
      t1_q        <= '0;
      t2_q        <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      t1_q    <= t1_d;
      t2_q    <= t1_q;
      if (do_vertex) begin
        cnt_q <= 6'd0;
        xf_q  <= 1'b0;
        xa_q  <= 2'd0;
        xc_q  <= 2'd0;
      end else if (issue_b) begin
        if (cnt_q == 6'd47) begin
          xf_q <= 1'b1;
        end
        cnt_q <= cnt_q + 6'd1;
      end else if (issue_x) begin
        xc_q <= xc_q + 2'd1;
        if (xc_q == 2'd3) begin
          xa_q <= xa_q + 2'd1;
        end
      end
      if (state_q == ST_UPD) begin
        seen_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!seen_q || (p_q[i] < box_min_q[i])) begin
            box_min_q[i] <= p_q[i];
          end
          if (!seen_q || (p_q[i] > box_max_q[i])) begin
            box_max_q[i] <= p_q[i];
          end
        end
      end else if (do_report) begin
        seen_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          box_min_q[i] <= '0;
          box_max_q[i] <= '0;
        end
      end
      if (do_report) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign box_valid_o = ob_valid_q;
  assign min_x_o     = omin_q[0];
  assign min_y_o     = omin_q[1];
  assign min_z_o     = omin_q[2];
  assign max_x_o     = omax_q[0];
  assign max_y_o     = omax_q[1];
  assign max_z_o     = omax_q[2];

  a_pipe_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t2_q.v |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("MAC pipeline active outside a vertex");

  a_upd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (!t1_q.v && !t2_q.v))
    else $error("box update before the pipeline drained");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_report |=> (!seen_q && out_valid_q))
    else $error("report did not clear the box");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (box_min_q[0] <= box_max_q[0] && box_min_q[1] <= box_max_q[1] &&
                box_min_q[2] <= box_max_q[2]))
    else $error("box minimum above maximum");

endmodule
